### rtl/tmhq_pkg.sv
package tmhq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_NONE   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] time_value;
    } req_t;

    typedef struct packed {
        logic [31:0] timer_id;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] timer_id;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_POP_RD,
        S_POP_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP
    } state_t;

    // earlier expiry first, then the older timer by age against the id counter
    function automatic logic ranks_before(entry_t a, entry_t b, logic [31:0] cnt);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = cnt - a.timer_id;
        age_b = cnt - b.timer_id;
        if (a.expiry != b.expiry)
            return a.expiry < b.expiry;
        return age_a > age_b;
    endfunction

endpackage

### rtl/timer_min_heap_queue.sv
// push: full answers via S_FIN; else the entry climbs one level per S_UP_RD/S_UP_CMP pair
// pop: S_FIN answers when empty, S_POP_CHK when nothing is due; else S_DN_RD/S_DN_CMP sift down
// each heap level costs one read of the registered-read heap memory and one compare/write
// one item at a time: start is taken only while busy is low; done pulses for one cycle
// reset clears the entry count, the id counter and control; heap memory is not cleared
module timer_min_heap_queue #(
    parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tmhq_pkg::req_t    req,
    output logic              busy,
    output logic              done,
    output tmhq_pkg::result_t result
);
    import tmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   idc_reg, idc_next;
    logic [AW-1:0] pos_reg, pos_next;
    entry_t        item_reg, item_next;
    logic [31:0]   tv_reg, tv_next;
    result_t       res_reg, res_next;
    logic          done_reg, done_next;

    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    entry_t        rdata_a;
    entry_t        rdata_b;

    logic [AW-1:0] parent;
    logic [IW-1:0] l_idx;
    logic [IW-1:0] r_idx;
    logic          l_ok;
    logic          r_ok;
    logic          full;
    logic          up_move;
    logic          due;
    logic          c_l_item;
    logic          c_r_item;
    logic          c_r_l;
    logic          pick_l;
    logic          pick_r;

    tmhq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign l_idx    = {pos_reg, 1'b1};
    assign r_idx    = l_idx + IW'(1);
    assign l_ok     = l_idx < IW'(count_reg);
    assign r_ok     = l_ok && (r_idx < IW'(count_reg));
    assign full     = count_reg == CW'(CAPACITY);
    assign up_move  = ranks_before(item_reg, rdata_a, idc_reg);
    assign due      = rdata_a.expiry <= tv_reg;
    assign c_l_item = ranks_before(rdata_a, item_reg, idc_reg);
    assign c_r_item = ranks_before(rdata_b, item_reg, idc_reg);
    assign c_r_l    = ranks_before(rdata_b, rdata_a, idc_reg);
    assign pick_r   = r_ok && (c_l_item ? c_r_l : c_r_item);
    assign pick_l   = c_l_item && !pick_r;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.req_type == REQ_POP)
                        state_next = S_POP_RD;
                    else if (full)
                        state_next = S_FIN;
                    else
                        state_next = S_UP_RD;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            S_POP_RD:
            begin
                state_next = (count_reg == '0) ? S_FIN : S_POP_CHK;
            end
            S_POP_CHK:
            begin
                if (due && count_reg != CW'(1))
                    state_next = S_DN_RD;
                else
                    state_next = S_IDLE;
            end
            S_UP_RD:
            begin
                state_next = (pos_reg == '0) ? S_IDLE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = up_move ? S_UP_RD : S_IDLE;
            end
            S_DN_RD:
            begin
                state_next = l_ok ? S_DN_CMP : S_IDLE;
            end
            S_DN_CMP:
            begin
                state_next = (pick_l || pick_r) ? S_DN_RD : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next = count_reg;
        idc_next   = idc_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        tv_next    = tv_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = item_reg;
        raddr_a    = '0;
        raddr_b    = AW'(count_reg - CW'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    tv_next = req.time_value;
                    if (req.req_type == REQ_PUSH)
                    begin
                        if (full)
                        begin
                            res_next = '{timer_id: '0, status: ST_FULL};
                        end
                        else
                        begin
                            idc_next   = idc_reg + 32'd1;
                            count_next = count_reg + CW'(1);
                            pos_next   = AW'(count_reg);
                            item_next  = '{expiry: req.time_value, timer_id: idc_reg + 32'd1};
                            res_next   = '{timer_id: idc_reg + 32'd1, status: ST_PUSHED};
                        end
                    end
                end
            end
            S_FIN:
            begin
            end
            S_POP_RD:
            begin
                if (count_reg == '0)
                    res_next = '{timer_id: '0, status: ST_NONE};
            end
            S_POP_CHK:
            begin
                if (due)
                begin
                    res_next   = '{timer_id: rdata_a.timer_id, status: ST_POPPED};
                    count_next = count_reg - CW'(1);
                    item_next  = rdata_b;
                    pos_next   = '0;
                end
                else
                begin
                    res_next = '{timer_id: '0, status: ST_NONE};
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                    we = 1'b1;
                else
                    raddr_a = parent;
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (up_move)
                begin
                    wdata    = rdata_a;
                    pos_next = parent;
                end
            end
            S_DN_RD:
            begin
                raddr_a = AW'(l_idx);
                raddr_b = AW'(r_idx);
                if (!l_ok)
                    we = 1'b1;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (pick_r)
                begin
                    wdata    = rdata_b;
                    pos_next = AW'(r_idx);
                end
                else if (pick_l)
                begin
                    wdata    = rdata_a;
                    pos_next = AW'(l_idx);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done_next = (state_reg != S_IDLE) && (state_next == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        item_reg <= item_next;
        tv_reg   <= tv_next;
        res_reg  <= res_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the queue busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while still busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> count_reg == CW'(CAPACITY))
        else $error("full status with free space");

    a_push_id: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_PUSHED |-> result.timer_id == idc_reg)
        else $error("pushed id differs from id counter");
`endif

endmodule

### rtl/tmhq_ram.sv
module tmhq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tmhq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output tmhq_pkg::entry_t rdata_a,
    output tmhq_pkg::entry_t rdata_b
);
    import tmhq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import tmhq_pkg::*;

    localparam int HEAP_DEPTH = CAPACITY_DEF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    req_t    req = '0;
    logic    busy;
    logic    done;
    result_t result;

    int          sender_idle_pct = 33;
    int          error_count = 0;
    result_t     outcomes_owed [$];

    logic [31:0] mdl_expiry [HEAP_DEPTH];
    logic [31:0] mdl_id [HEAP_DEPTH];
    int          mdl_count = 0;
    logic [31:0] mdl_counter = '0;

    timer_min_heap_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("timer_min_heap_queue: mismatch");
        $finish;
    end

    // earlier expiry wins, ties go to the older timer by age against the counter
    function automatic bit sits_above(int a, int b);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = mdl_counter - mdl_id[a];
        age_b = mdl_counter - mdl_id[b];
        if (mdl_expiry[a] != mdl_expiry[b])
            return mdl_expiry[a] < mdl_expiry[b];
        return age_a > age_b;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [31:0] e;
        logic [31:0] t;
        e = mdl_expiry[a];
        t = mdl_id[a];
        mdl_expiry[a] = mdl_expiry[b];
        mdl_id[a] = mdl_id[b];
        mdl_expiry[b] = e;
        mdl_id[b] = t;
    endfunction

    function automatic result_t timer_heap_step(req_t r);
        result_t res;
        int      pos;
        int      parent;
        int      best;
        int      lc;
        int      rc;
        res.timer_id = '0;
        res.status = ST_NONE;
        if (r.req_type == REQ_PUSH)
        begin
            if (mdl_count >= HEAP_DEPTH)
                res.status = ST_FULL;
            else
            begin
                mdl_counter = mdl_counter + 32'd1;
                res.timer_id = mdl_counter;
                pos = mdl_count;
                mdl_expiry[pos] = r.time_value;
                mdl_id[pos] = mdl_counter;
                mdl_count++;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!sits_above(pos, parent))
                        break;
                    swap_slots(pos, parent);
                    pos = parent;
                end
                res.status = ST_PUSHED;
            end
        end
        else
        begin
            if (mdl_count == 0 || mdl_expiry[0] > r.time_value)
                res.status = ST_NONE;
            else
            begin
                res.timer_id = mdl_id[0];
                mdl_count--;
                if (mdl_count > 0)
                begin
                    mdl_expiry[0] = mdl_expiry[mdl_count];
                    mdl_id[0] = mdl_id[mdl_count];
                    pos = 0;
                    forever
                    begin
                        best = pos;
                        lc = 2 * pos + 1;
                        rc = lc + 1;
                        if (lc < mdl_count && sits_above(lc, best))
                            best = lc;
                        if (rc < mdl_count && sits_above(rc, best))
                            best = rc;
                        if (best == pos)
                            break;
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
                res.status = ST_POPPED;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_word(logic kind, logic [31:0] tv);
        req_t r;
        r.req_type = kind;
        r.time_value = tv;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        outcomes_owed.push_back(timer_heap_step(r));
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (outcomes_owed.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_words
        result_t want;
        if (rst_n && done)
        begin
            if (outcomes_owed.size() == 0)
                report_mismatch($sformatf("unexpected word id=%08h status=%0d",
                                          result.timer_id, result.status));
            else
            begin
                want = outcomes_owed.pop_front();
                if (result.timer_id !== want.timer_id)
                    report_mismatch($sformatf("timer_id %08h, wanted %08h",
                                              result.timer_id, want.timer_id));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              result.status, want.status));
            end
        end
    end

    task automatic test_empty_heap();
        send_word(REQ_POP, 32'h0000_0000);
        send_word(REQ_POP, 32'hFFFF_FFFF);
    endtask

    task automatic test_extreme_times();
        send_word(REQ_PUSH, 32'hFFFF_FFFF);
        send_word(REQ_PUSH, 32'h0000_0000);
        send_word(REQ_POP, 32'h0000_0000);
        send_word(REQ_POP, 32'hFFFF_FFFE);
        send_word(REQ_POP, 32'hFFFF_FFFF);
        send_word(REQ_POP, 32'hFFFF_FFFF);
    endtask

    task automatic test_equal_expiry();
        send_word(REQ_PUSH, 32'd100);
        send_word(REQ_PUSH, 32'd100);
        send_word(REQ_PUSH, 32'd50);
        send_word(REQ_PUSH, 32'd100);
        send_word(REQ_POP, 32'd49);
        repeat (4)
            send_word(REQ_POP, 32'd100);
    endtask

    task automatic test_not_due();
        send_word(REQ_PUSH, 32'd1000);
        send_word(REQ_POP, 32'd999);
        send_word(REQ_POP, 32'd1000);
    endtask

    task automatic test_random_traffic(int n, logic [31:0] start_time);
        logic [31:0] now;
        logic [31:0] tv;
        logic [31:0] last_expiry;
        int          push_pct;
        int          sel;
        now = start_time;
        last_expiry = start_time;
        for (int i = 0; i < n; i++)
        begin
            push_pct = (mdl_count < 4) ? 70 : (mdl_count > 56) ? 30 : 50;
            sel = $urandom_range(9);
            if ($urandom_range(99) < push_pct)
            begin
                if (sel == 0)
                    tv = $urandom;
                else if (sel == 1)
                    tv = last_expiry;
                else if (sel == 2)
                    tv = now;
                else
                    tv = now + $urandom_range(300);
                last_expiry = tv;
                send_word(REQ_PUSH, tv);
            end
            else
            begin
                if (sel == 0)
                    tv = $urandom;
                else if (sel == 1)
                    tv = now - $urandom_range(100);
                else
                    tv = now;
                now = now + $urandom_range(40);
                send_word(REQ_POP, tv);
            end
        end
    endtask

    task automatic test_fill_and_drain();
        while (mdl_count < HEAP_DEPTH)
        begin
            if ($urandom_range(1))
                send_word(REQ_PUSH, $urandom_range(15));
            else
                send_word(REQ_PUSH, $urandom);
        end
        repeat (2)
            send_word(REQ_PUSH, $urandom);
        send_word(REQ_POP, $urandom);
        while (mdl_count > 0)
            send_word(REQ_POP, 32'hFFFF_FFFF);
        send_word(REQ_POP, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 33;
        test_empty_heap();
        test_extreme_times();
        test_equal_expiry();
        test_not_due();
        wait_for_results();

        test_random_traffic(250, $urandom);
        test_fill_and_drain();
        wait_for_results();

        sender_idle_pct = 49;
        test_random_traffic(250, 32'hFFFF_FF00);
        test_fill_and_drain();

        sender_idle_pct = 0;
        test_random_traffic(250, 32'h0000_0000);

        start <= 1'b0;
        wait_for_results();
        repeat (30)
            @(posedge clk);
        if (error_count == 0)
            $display("timer_min_heap_queue: match");
        else
            $display("timer_min_heap_queue: mismatch");
        $finish;
    end

endmodule
